// File: hw/rtl/binary_min_heap_queue_defines.svh
// Assertion macros shared by the queue RTL.
`ifndef BINARY_MIN_HEAP_QUEUE_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
// Check that the consequent holds in the same cycle as the antecedent.
`define BMHQ_ASSERT_SAME(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("binary_min_heap_queue: assertion failed");
// Check that the consequent holds in the cycle after the antecedent.
`define BMHQ_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("binary_min_heap_queue: assertion failed");
`else
`define BMHQ_ASSERT_SAME(lbl, pre, post)
`define BMHQ_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

// File: hw/rtl/bmhq_pkg.sv
package bmhq_pkg;

	// Default sizing
	localparam int unsigned HEAP_DEPTH_DEF   = 4096;
	localparam int unsigned KEY_BITS_DEF     = 16;
	localparam int unsigned PAYLOAD_BITS_DEF = 24;

	// Operation codes
	typedef enum logic {
		OP_INSERT  = 1'b0,
		OP_EXTRACT = 1'b1
	} op_t;

	// Result status codes
	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_CHK,
		S_UP_CMP,
		S_EX_LD,
		S_DN_CHK,
		S_DN_CMP,
		S_DONE
	} state_t;

endpackage

// File: hw/rtl/binary_min_heap_queue.sv
// Binary min-heap priority queue of (key, payload) entries held in one synchronous RAM with
// two read ports and one write port. Issue a transaction by raising start while busy is low;
// operation 0 inserts key/payload, operation 1 extracts the entry with the smallest key.
// Every transaction yields exactly one result, shown for a single cycle with done high; the
// receiver cannot stall it, so sample status, out_key, out_payload and occupancy on done.
// Insert into a full queue reports status 2, extract from an empty queue status 1, and
// neither changes anything. Each heap level is a RAM read followed by a compare and
// write-back: an insert climbs from the new last position towards the root, and an extract
// reads the root and the last entry, then descends from the root until the entry settles.
// With the default depth of 4096 an insert climbs at most 12 levels, and start is accepted
// again the cycle after done.
`include "binary_min_heap_queue_defines.svh"

module binary_min_heap_queue #(
	parameter int unsigned HEAP_DEPTH   = bmhq_pkg::HEAP_DEPTH_DEF,
	parameter int unsigned KEY_BITS     = bmhq_pkg::KEY_BITS_DEF,
	parameter int unsigned PAYLOAD_BITS = bmhq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic                             operation,
	input  logic [KEY_BITS-1:0]              key,
	input  logic [PAYLOAD_BITS-1:0]          payload,
	output logic                             done,
	output logic [1:0]                       status,
	output logic [KEY_BITS-1:0]              out_key,
	output logic [PAYLOAD_BITS-1:0]          out_payload,
	output logic [$clog2(HEAP_DEPTH+1)-1:0]  occupancy
);

	localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
	localparam int unsigned AW = $clog2(HEAP_DEPTH);
	localparam int unsigned EW = KEY_BITS + PAYLOAD_BITS;

	bmhq_pkg::state_t  state_q, state_d;
	bmhq_pkg::status_t status_q;

	logic [CW-1:0]       count_q;
	logic [CW-1:0]       pos_q;
	logic [CW-1:0]       left_q;
	logic                has_right_q;
	logic [EW-1:0]       mv_q;
	logic [KEY_BITS-1:0]     out_key_q;
	logic [PAYLOAD_BITS-1:0] out_payload_q;

	logic [EW-1:0] mem [HEAP_DEPTH];
	logic [EW-1:0] rd_a_q, rd_b_q;

	logic          accept;
	logic          is_extract;
	logic          full, empty;
	logic [CW:0]   left_w;
	logic          leaf;
	logic          has_right_w;
	logic          up_swap;
	logic          pick_right;
	logic [EW-1:0] pick;
	logic [CW-1:0] pick_pos;
	logic          dn_swap;

	logic          mem_we;
	logic [EW-1:0] wr_data;
	logic [AW-1:0] wr_addr;
	logic [CW-1:0] rd_pos_a, rd_pos_b;
	logic [CW-1:0] wr_idx, rd_idx_a, rd_idx_b;
	logic [AW-1:0] rd_addr_a, rd_addr_b;

	// Decode the transaction and the sift decisions
	assign accept      = start && !busy;
	assign is_extract  = (operation == bmhq_pkg::OP_EXTRACT);
	assign full        = (count_q == CW'(HEAP_DEPTH));
	assign empty       = (count_q == '0);
	assign left_w      = {pos_q, 1'b0};
	assign leaf        = (left_w > {1'b0, count_q});
	assign has_right_w = ((left_w + 1'b1) <= {1'b0, count_q});
	assign up_swap     = (rd_a_q[EW-1 -: KEY_BITS] > mv_q[EW-1 -: KEY_BITS]);
	assign pick_right  = has_right_q && (rd_b_q[EW-1 -: KEY_BITS] < rd_a_q[EW-1 -: KEY_BITS]);
	assign pick        = pick_right ? rd_b_q : rd_a_q;
	assign pick_pos    = left_q + CW'(pick_right);
	assign dn_swap     = (pick[EW-1 -: KEY_BITS] <= mv_q[EW-1 -: KEY_BITS]);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			bmhq_pkg::S_IDLE: begin
				if (start) begin
					if (is_extract) begin
						state_d = empty ? bmhq_pkg::S_DONE : bmhq_pkg::S_EX_LD;
					end else begin
						state_d = full ? bmhq_pkg::S_DONE : bmhq_pkg::S_UP_CHK;
					end
				end
			end
			bmhq_pkg::S_UP_CHK: begin
				state_d = (pos_q == CW'(1)) ? bmhq_pkg::S_DONE : bmhq_pkg::S_UP_CMP;
			end
			bmhq_pkg::S_UP_CMP: begin
				state_d = up_swap ? bmhq_pkg::S_UP_CHK : bmhq_pkg::S_DONE;
			end
			bmhq_pkg::S_EX_LD: begin
				state_d = bmhq_pkg::S_DN_CHK;
			end
			bmhq_pkg::S_DN_CHK: begin
				state_d = leaf ? bmhq_pkg::S_DONE : bmhq_pkg::S_DN_CMP;
			end
			bmhq_pkg::S_DN_CMP: begin
				state_d = dn_swap ? bmhq_pkg::S_DN_CHK : bmhq_pkg::S_DONE;
			end
			bmhq_pkg::S_DONE: begin
				state_d = bmhq_pkg::S_IDLE;
			end
			default: begin
				state_d = bmhq_pkg::S_IDLE;
			end
		endcase
	end

	// Outputs and memory port control
	always_comb begin
		busy     = 1'b1;
		done     = 1'b0;
		mem_we   = 1'b0;
		wr_data  = mv_q;
		rd_pos_a = CW'(1);
		rd_pos_b = count_q;
		case (state_q)
			bmhq_pkg::S_IDLE: begin
				busy = 1'b0;
			end
			bmhq_pkg::S_UP_CHK: begin
				rd_pos_a = pos_q >> 1;
				mem_we   = (pos_q == CW'(1));
			end
			bmhq_pkg::S_UP_CMP: begin
				mem_we  = 1'b1;
				wr_data = up_swap ? rd_a_q : mv_q;
			end
			bmhq_pkg::S_EX_LD: begin
			end
			bmhq_pkg::S_DN_CHK: begin
				rd_pos_a = left_w[CW-1:0];
				rd_pos_b = left_w[CW-1:0] + 1'b1;
				mem_we   = leaf;
			end
			bmhq_pkg::S_DN_CMP: begin
				mem_we  = 1'b1;
				wr_data = dn_swap ? pick : mv_q;
			end
			bmhq_pkg::S_DONE: begin
				done = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Map 1-based heap positions to RAM addresses
	assign wr_idx    = pos_q - 1'b1;
	assign rd_idx_a  = rd_pos_a - 1'b1;
	assign rd_idx_b  = rd_pos_b - 1'b1;
	assign wr_addr   = wr_idx[AW-1:0];
	assign rd_addr_a = rd_idx_a[AW-1:0];
	assign rd_addr_b = rd_idx_b[AW-1:0];

	// Heap RAM: one write, two registered reads
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_a_q <= mem[rd_addr_a];
		rd_b_q <= mem[rd_addr_b];
	end

	// Hold control state and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bmhq_pkg::S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				if (is_extract && !empty) begin
					count_q <= count_q - 1'b1;
				end else if (!is_extract && !full) begin
					count_q <= count_q + 1'b1;
				end
			end
		end
	end

	// Advance the moving entry, hole position and result fields
	always_ff @(posedge clk) begin
		if (accept) begin
			out_key_q     <= '0;
			out_payload_q <= '0;
			mv_q          <= {key, payload};
			if (is_extract) begin
				pos_q    <= CW'(1);
				status_q <= empty ? bmhq_pkg::ST_EMPTY : bmhq_pkg::ST_DONE;
			end else begin
				pos_q    <= count_q + 1'b1;
				status_q <= full ? bmhq_pkg::ST_FULL : bmhq_pkg::ST_DONE;
			end
		end
		if (state_q == bmhq_pkg::S_UP_CMP && up_swap) begin
			pos_q <= pos_q >> 1;
		end
		if (state_q == bmhq_pkg::S_EX_LD) begin
			out_key_q     <= rd_a_q[EW-1 -: KEY_BITS];
			out_payload_q <= rd_a_q[PAYLOAD_BITS-1:0];
			mv_q          <= rd_b_q;
		end
		if (state_q == bmhq_pkg::S_DN_CHK) begin
			left_q      <= left_w[CW-1:0];
			has_right_q <= has_right_w;
		end
		if (state_q == bmhq_pkg::S_DN_CMP && dn_swap) begin
			pos_q <= pick_pos;
		end
	end

	assign status      = status_q;
	assign out_key     = out_key_q;
	assign out_payload = out_payload_q;
	assign occupancy   = count_q;

	// Checks on count bookkeeping, write range and result fields
	`BMHQ_ASSERT_NEXT(a_ins_count, accept && !is_extract && !full, count_q == $past(count_q) + 1'b1)
	`BMHQ_ASSERT_NEXT(a_ext_count, accept && is_extract && !empty, count_q == $past(count_q) - 1'b1)
	`BMHQ_ASSERT_SAME(a_wr_range, mem_we, (CW+1)'(pos_q) <= (CW+1)'(count_q) + 1'b1)
	`BMHQ_ASSERT_SAME(a_full_cnt, done && status_q == bmhq_pkg::ST_FULL, full)
	`BMHQ_ASSERT_SAME(a_err_zero, done && status_q != bmhq_pkg::ST_DONE, out_key_q == '0 && out_payload_q == '0)

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned DEPTH        = bmhq_pkg::HEAP_DEPTH_DEF;
	localparam int unsigned KEY_W        = bmhq_pkg::KEY_BITS_DEF;
	localparam int unsigned PAY_W        = bmhq_pkg::PAYLOAD_BITS_DEF;
	localparam int unsigned OCC_W        = $clog2(DEPTH + 1);
	localparam int unsigned RANDOM_ITEMS = 1150;
	localparam int unsigned DRAIN_CYCLES = 40;
	localparam int unsigned PRINT_CAP    = 50;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic [PAY_W-1:0] payload;
	} heap_entry_t;

	typedef struct {
		bmhq_pkg::status_t status;
		logic [KEY_W-1:0]  key;
		logic [PAY_W-1:0]  payload;
		logic [OCC_W-1:0]  occupancy;
	} heap_result_t;

	// Mirror of the heap contents plus the queue of results still owed by the block
	class min_heap_tracker;
		heap_entry_t  mirror_slots [0:DEPTH];
		int unsigned  live;
		heap_result_t awaited_results [$];
		int unsigned  errors;
		int unsigned  checked;
		int unsigned  inserts;
		int unsigned  extracts;
		int unsigned  full_hits;
		int unsigned  empty_hits;
		int unsigned  peak;

		function new();
			live = 0;
			errors = 0;
			checked = 0;
			inserts = 0;
			extracts = 0;
			full_hits = 0;
			empty_hits = 0;
			peak = 0;
		endfunction

		function int unsigned pending();
			return awaited_results.size();
		endfunction

		task report(string msg);
			errors++;
			if (errors <= PRINT_CAP)
				$display("MISMATCH at %0t: %s", $realtime, msg);
		endtask

		function void swap_slots(int unsigned a, int unsigned b);
			heap_entry_t tmp;
			tmp = mirror_slots[a];
			mirror_slots[a] = mirror_slots[b];
			mirror_slots[b] = tmp;
		endfunction

		// Apply one accepted transaction to the mirror and queue the result it owes
		function void note_request(bmhq_pkg::op_t op, logic [KEY_W-1:0] k,
				logic [PAY_W-1:0] p);
			heap_result_t r;
			int unsigned  pos;
			int unsigned  left;
			int unsigned  pick;
			r.status  = bmhq_pkg::ST_DONE;
			r.key     = '0;
			r.payload = '0;
			if (op == bmhq_pkg::OP_INSERT) begin
				if (live >= DEPTH) begin
					r.status = bmhq_pkg::ST_FULL;
					full_hits++;
				end else begin
					// append, then climb while the parent is strictly greater
					live++;
					mirror_slots[live] = '{key: k, payload: p};
					pos = live;
					while (pos > 1 && mirror_slots[pos / 2].key > mirror_slots[pos].key) begin
						swap_slots(pos, pos / 2);
						pos = pos / 2;
					end
					inserts++;
				end
			end else begin
				if (live == 0) begin
					r.status = bmhq_pkg::ST_EMPTY;
					empty_hits++;
				end else begin
					// take the root, move the last entry up and sink it
					r.key     = mirror_slots[1].key;
					r.payload = mirror_slots[1].payload;
					mirror_slots[1] = mirror_slots[live];
					live--;
					pos = 1;
					while (2 * pos <= live) begin
						left = 2 * pos;
						pick = left;
						if (left + 1 <= live &&
						    mirror_slots[left + 1].key < mirror_slots[left].key)
							pick = left + 1;
						if (mirror_slots[pick].key > mirror_slots[pos].key)
							break;
						swap_slots(pos, pick);
						pos = pick;
					end
					extracts++;
				end
			end
			r.occupancy = OCC_W'(live);
			if (live > peak)
				peak = live;
			awaited_results.push_back(r);
		endfunction

		// Compare one strobed result against the oldest owed result
		task match_result(logic [1:0] st, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p,
				logic [OCC_W-1:0] occ);
			heap_result_t w;
			checked++;
			if (awaited_results.size() == 0) begin
				report("result strobed with no transaction outstanding");
				return;
			end
			w = awaited_results.pop_front();
			if (st !== w.status)
				report($sformatf("status got %0d want %0d", st, w.status));
			if (k !== w.key)
				report($sformatf("out_key got %h want %h", k, w.key));
			if (p !== w.payload)
				report($sformatf("out_payload got %h want %h", p, w.payload));
			if (occ !== w.occupancy)
				report($sformatf("occupancy got %0d want %0d", occ, w.occupancy));
		endtask
	endclass

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic             operation;
	logic [KEY_W-1:0] key;
	logic [PAY_W-1:0] payload;
	logic             done;
	logic [1:0]       status;
	logic [KEY_W-1:0] out_key;
	logic [PAY_W-1:0] out_payload;
	logic [OCC_W-1:0] occupancy;

	min_heap_tracker tracker = new();

	binary_min_heap_queue dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.key         (key),
		.payload     (payload),
		.done        (done),
		.status      (status),
		.out_key     (out_key),
		.out_payload (out_payload),
		.occupancy   (occupancy)
	);

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hold start with the fields until the block takes the transaction
	task automatic issue(bmhq_pkg::op_t op, logic [KEY_W-1:0] k, logic [PAY_W-1:0] p);
		@(negedge clk);
		start     = 1'b1;
		operation = op;
		key       = k;
		payload   = p;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		tracker.note_request(op, k, p);
	endtask

	// Drop start and scramble the idle fields while idling
	task automatic idle(int unsigned n);
		repeat (n) begin
			@(negedge clk);
			start     = 1'b0;
			operation = 1'($urandom);
			key       = KEY_W'($urandom);
			payload   = PAY_W'($urandom);
		end
	endtask

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 30);
		return $urandom_range(31, 60);
	endfunction

	// Favour narrow key ranges so that ties are common
	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return KEY_W'($urandom_range(0, 7));
			4:          return ($urandom_range(0, 1) == 0) ? '0 : '1;
			5:          return '1 - KEY_W'($urandom_range(0, 7));
			default:    return KEY_W'($urandom);
		endcase
	endfunction

	function automatic logic [PAY_W-1:0] pick_payload();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			default: return PAY_W'($urandom);
		endcase
	endfunction

	// Check every strobed result
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && done)
				tracker.match_result(status, out_key, out_payload, occupancy);
		end
	end

	// Overall limit on the run
	initial begin
		#(5_000_000);
		$display("Run timed out with %0d results outstanding", tracker.pending());
		$display("== FAIL ==");
		$finish;
	end

	// Stimulus
	initial begin
		int unsigned sent;
		int unsigned ins_pct;
		bit          calm;

		arst_n    = 1'b0;
		start     = 1'b0;
		operation = bmhq_pkg::OP_INSERT;
		key       = '0;
		payload   = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty extract, extremes, ties on equal keys, bit patterns
		issue(bmhq_pkg::OP_EXTRACT, '1, '1);
		issue(bmhq_pkg::OP_INSERT, '0, '0);
		issue(bmhq_pkg::OP_INSERT, '1, '1);
		issue(bmhq_pkg::OP_INSERT, KEY_W'(5), PAY_W'(24'h00000A));
		idle(3);
		issue(bmhq_pkg::OP_INSERT, KEY_W'(5), PAY_W'(24'h00000B));
		issue(bmhq_pkg::OP_INSERT, KEY_W'(5), PAY_W'(24'h00000C));
		issue(bmhq_pkg::OP_INSERT, KEY_W'(3), PAY_W'(24'h123456));
		issue(bmhq_pkg::OP_INSERT, KEY_W'(16'hAAAA), PAY_W'(24'h555555));
		issue(bmhq_pkg::OP_INSERT, KEY_W'(16'h5555), PAY_W'(24'hAAAAAA));
		repeat (8) begin
			issue(bmhq_pkg::OP_EXTRACT, KEY_W'($urandom), PAY_W'($urandom));
			idle(pick_gap());
		end
		issue(bmhq_pkg::OP_EXTRACT, '0, '0);
		issue(bmhq_pkg::OP_EXTRACT, '1, '1);
		issue(bmhq_pkg::OP_INSERT, '1, '0);
		issue(bmhq_pkg::OP_INSERT, '1, '1);
		issue(bmhq_pkg::OP_EXTRACT, '0, '0);
		issue(bmhq_pkg::OP_EXTRACT, '0, '0);

		// Random mix: windows lean towards insert, extract or neither
		sent    = 0;
		ins_pct = 55;
		calm    = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			if (sent % 64 == 0) begin
				case ($urandom_range(0, 3))
					0:       ins_pct = 80;
					1:       ins_pct = 25;
					default: ins_pct = 55;
				endcase
				calm = ($urandom_range(0, 3) == 0);
			end
			if ($urandom_range(1, 100) <= ins_pct)
				issue(bmhq_pkg::OP_INSERT, pick_key(), pick_payload());
			else
				issue(bmhq_pkg::OP_EXTRACT, KEY_W'($urandom), PAY_W'($urandom));
			sent++;
			if (!calm)
				idle(pick_gap());
		end
		idle(1);

		// Wait for the last results, then watch for strays
		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d inserts, %0d extracts, %0d full and %0d empty rejections",
			tracker.inserts, tracker.extracts, tracker.full_hits, tracker.empty_hits);
		$display("Peak occupancy %0d of %0d; %0d results checked, %0d mismatches",
			tracker.peak, DEPTH, tracker.checked, tracker.errors);
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/bmhq_pkg.sv
hw/rtl/binary_min_heap_queue.sv
dv/tb_top.sv
